// ----- sv/hmt_pkg.sv -----
package hmt_pkg;

    // Table size and the width of an entry count (holds 0..TABLE_DEPTH)
    localparam int TABLE_DEPTH = 32;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Fixed field widths
    localparam int ID_W    = 16;
    localparam int PORT_W  = 16;
    localparam int HB_W    = 32;
    localparam int TIME_W  = 32;
    localparam int ACT_W   = 2;
    localparam int KIND_W  = 3;
    localparam int COUNT_W = 6;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SELF_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_PORT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAIL_AGE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REMOVE_AGE = 2'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0] SELF_ID_RST    = 16'd0;
    localparam logic [CFG_W-1:0] SELF_PORT_RST  = 16'd0;
    localparam logic [CFG_W-1:0] FAIL_AGE_RST   = 16'd5;
    localparam logic [CFG_W-1:0] REMOVE_AGE_RST = 16'd20;

    typedef enum logic [ACT_W-1:0] {
        ACT_MERGE  = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_GOSSIP = 2'd2
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_UPDATED   = 3'd0,
        KIND_UNCHANGED = 3'd1,
        KIND_ADDED     = 3'd2,
        KIND_SELF      = 3'd3,
        KIND_FULL      = 3'd4,
        KIND_REMOVED   = 3'd5,
        KIND_GOSSIP    = 3'd6,
        KIND_TICK_DONE = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN,
        ST_FINAL
    } state_t;

    // Operation applied to the ring of cells in one cycle
    typedef enum logic [1:0] {
        RING_HOLD,
        RING_ROT,
        RING_DROP,
        RING_APPEND
    } ring_op_t;

    // Source selected by one cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_NEXT,
        CELL_FEED,
        CELL_NEW
    } cell_sel_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
        logic [HB_W-1:0]   hb;
        logic [TIME_W-1:0] tm;
    } entry_t;

    typedef struct packed {
        logic [CFG_W-1:0] self_id;
        logic [CFG_W-1:0] self_port;
        logic [CFG_W-1:0] fail_age;
        logic [CFG_W-1:0] remove_age;
    } cfg_t;

    // Ring control from the sequencer to the cells
    typedef struct packed {
        ring_op_t         op;
        logic [CNT_W-1:0] pos;
        entry_t           feed;
        entry_t           fresh;
    } ring_ctl_t;

endpackage

// ----- sv/heartbeat_membership_table.sv -----
// Gossip membership table held in a ring of TABLE_DEPTH cells, one peer entry
// per cell. Every merge, tick or gossip word walks the valid entries past the
// head cell, one entry per clock, so a merge or gossip word makes one pass over
// the table and a tick makes two (one pass to count the survivors so that
// removal results carry the final count, one pass to report and compact).
// Each result waits in an output register; the walk pauses while a result
// cannot be handed over. A new word is taken once the last result of the
// previous one is in the output register. Configuration writes take effect
// at once and should be made while no word is in flight. Action code 3 is
// taken and ignored.
module heartbeat_membership_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [hmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hmt_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic [hmt_pkg::ACT_W-1:0]      action,
    input  logic [hmt_pkg::ID_W-1:0]       entry_id,
    input  logic [hmt_pkg::PORT_W-1:0]     entry_port,
    input  logic [hmt_pkg::HB_W-1:0]       entry_heartbeat,
    input  logic [hmt_pkg::TIME_W-1:0]     entry_time,
    input  logic [hmt_pkg::TIME_W-1:0]     now,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [hmt_pkg::KIND_W-1:0]     kind,
    output logic [hmt_pkg::ID_W-1:0]       peer_id,
    output logic [hmt_pkg::PORT_W-1:0]     peer_port,
    output logic [hmt_pkg::HB_W-1:0]       peer_heartbeat,
    output logic [hmt_pkg::TIME_W-1:0]     peer_time,
    output logic [hmt_pkg::COUNT_W-1:0]    table_count,
    output logic                           last
);
    import hmt_pkg::*;

    cfg_t       cfg_reg;
    ring_ctl_t  ring;
    entry_t     ent [TABLE_DEPTH];
    cell_sel_t  sel [TABLE_DEPTH];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.self_id    <= SELF_ID_RST;
            cfg_reg.self_port  <= SELF_PORT_RST;
            cfg_reg.fail_age   <= FAIL_AGE_RST;
            cfg_reg.remove_age <= REMOVE_AGE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SELF_ID:    cfg_reg.self_id    <= cfg_data;
                REG_SELF_PORT:  cfg_reg.self_port  <= cfg_data;
                REG_FAIL_AGE:   cfg_reg.fail_age   <= cfg_data;
                REG_REMOVE_AGE: cfg_reg.remove_age <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    hmt_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .head            (ent[0]),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .action          (action),
        .entry_id        (entry_id),
        .entry_port      (entry_port),
        .entry_heartbeat (entry_heartbeat),
        .entry_time      (entry_time),
        .now             (now),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .kind            (kind),
        .peer_id         (peer_id),
        .peer_port       (peer_port),
        .peer_heartbeat  (peer_heartbeat),
        .peer_time       (peer_time),
        .table_count     (table_count),
        .last            (last),
        .ring            (ring)
    );

    // Ring of cells: the segment below pos rotates toward the head or drops it; append fills cell pos
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX  = CNT_W'(i);
        localparam logic [CNT_W-1:0] IDX1 = CNT_W'(i + 1);

        always_comb
        begin
            case (ring.op)
                RING_ROT:
                begin
                    if (IDX1 < ring.pos)
                        sel[i] = CELL_NEXT;
                    else if (IDX1 == ring.pos)
                        sel[i] = CELL_FEED;
                    else
                        sel[i] = CELL_HOLD;
                end
                RING_DROP:
                begin
                    sel[i] = (IDX1 < ring.pos) ? CELL_NEXT : CELL_HOLD;
                end
                RING_APPEND:
                begin
                    sel[i] = (IDX == ring.pos) ? CELL_NEW : CELL_HOLD;
                end
                default:
                begin
                    sel[i] = CELL_HOLD;
                end
            endcase
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            hmt_cell u_cell (
                .clk      (clk),
                .sel      (sel[i]),
                .next_ent (ring.feed),
                .feed_ent (ring.feed),
                .new_ent  (ring.fresh),
                .ent      (ent[i])
            );
        end
        else
        begin : g_body
            hmt_cell u_cell (
                .clk      (clk),
                .sel      (sel[i]),
                .next_ent (ent[i+1]),
                .feed_ent (ring.feed),
                .new_ent  (ring.fresh),
                .ent      (ent[i])
            );
        end
    end

    // An append never lands beyond the last cell
    a_append_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ring.op == RING_APPEND |-> ring.pos < CNT_W'(TABLE_DEPTH))
        else $error("append beyond table depth");

    // A walk step always has a non-empty segment
    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (ring.op == RING_ROT || ring.op == RING_DROP) |-> ring.pos != '0)
        else $error("ring walk on an empty segment");

    // The tick summary closes its word
    a_tick_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_TICK_DONE |-> last)
        else $error("tick summary without last");

    // A real action keeps the input closed in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready &&
        (action == ACT_MERGE || action == ACT_TICK || action == ACT_GOSSIP)
        |=> !item_ready)
        else $error("input reopened while a word is in flight");

endmodule

// ----- sv/hmt_cell.sv -----
module hmt_cell (
    input  logic               clk,
    input  hmt_pkg::cell_sel_t sel,
    input  hmt_pkg::entry_t    next_ent,
    input  hmt_pkg::entry_t    feed_ent,
    input  hmt_pkg::entry_t    new_ent,
    output hmt_pkg::entry_t    ent
);
    import hmt_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;

    // Pick the source for this cell
    always_comb
    begin
        case (sel)
            CELL_NEXT: ent_next = next_ent;
            CELL_FEED: ent_next = feed_ent;
            CELL_NEW:  ent_next = new_ent;
            default:   ent_next = ent_reg;
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

// ----- sv/hmt_ctrl.sv -----
module hmt_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hmt_pkg::cfg_t                 cfg,
    input  hmt_pkg::entry_t               head,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [hmt_pkg::ACT_W-1:0]     action,
    input  logic [hmt_pkg::ID_W-1:0]      entry_id,
    input  logic [hmt_pkg::PORT_W-1:0]    entry_port,
    input  logic [hmt_pkg::HB_W-1:0]      entry_heartbeat,
    input  logic [hmt_pkg::TIME_W-1:0]    entry_time,
    input  logic [hmt_pkg::TIME_W-1:0]    now,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [hmt_pkg::KIND_W-1:0]    kind,
    output logic [hmt_pkg::ID_W-1:0]      peer_id,
    output logic [hmt_pkg::PORT_W-1:0]    peer_port,
    output logic [hmt_pkg::HB_W-1:0]      peer_heartbeat,
    output logic [hmt_pkg::TIME_W-1:0]    peer_time,
    output logic [hmt_pkg::COUNT_W-1:0]   table_count,
    output logic                          last,
    output hmt_pkg::ring_ctl_t            ring
);
    import hmt_pkg::*;

    state_t             state_reg, state_next;
    logic [ACT_W-1:0]   act_reg, act_next;
    logic [ID_W-1:0]    eid_reg, eid_next;
    logic [PORT_W-1:0]  eport_reg, eport_next;
    logic [HB_W-1:0]    ehb_reg, ehb_next;
    logic [TIME_W-1:0]  etime_reg, etime_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   bnd_reg, bnd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   keep_reg, keep_next;
    logic               found_reg, found_next;
    kind_t              res_kind_reg, res_kind_next;
    entry_t             res_ent_reg, res_ent_next;
    logic [HB_W-1:0]    own_hb_reg, own_hb_next;

    logic               out_valid_reg;
    kind_t              out_kind_reg;
    entry_t             out_ent_reg;
    logic [CNT_W-1:0]   out_cnt_reg;
    logic               out_last_reg;

    logic               load;
    kind_t              load_kind;
    entry_t             load_ent;
    logic [CNT_W-1:0]   load_cnt;
    logic               load_last;

    logic [TIME_W-1:0]  age;
    logic               age_fresh;
    logic               age_live;
    logic               match;
    logic               raise;
    logic               is_self;
    logic               full;
    logic               out_free;
    logic               emit;
    logic               step;
    entry_t             fresh;
    entry_t             self_ent;
    entry_t             upd_ent;

    // Evaluate the entry at the head of the ring
    assign age       = now_reg - head.tm;
    assign age_fresh = age <= {{(TIME_W-CFG_W){1'b0}}, cfg.fail_age};
    assign age_live  = age < {{(TIME_W-CFG_W){1'b0}}, cfg.remove_age};
    assign match     = (head.id == eid_reg) && (head.port == eport_reg);
    assign raise     = ehb_reg > head.hb;
    assign is_self   = (eid_reg == cfg.self_id) && (eport_reg == cfg.self_port);
    assign full      = cnt_reg == CNT_W'(TABLE_DEPTH);
    assign out_free  = !out_valid_reg || result_ready;

    assign fresh     = '{id: eid_reg, port: eport_reg, hb: ehb_reg, tm: etime_reg};
    assign self_ent  = '{id: cfg.self_id, port: cfg.self_port, hb: own_hb_reg, tm: now_reg};
    assign upd_ent   = '{id: head.id, port: head.port, hb: ehb_reg, tm: now_reg};

    assign item_ready = state_reg == ST_IDLE;

    // Sequence one word through the ring
    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        eid_next      = eid_reg;
        eport_next    = eport_reg;
        ehb_next      = ehb_reg;
        etime_next    = etime_reg;
        now_next      = now_reg;
        rem_next      = rem_reg;
        bnd_next      = bnd_reg;
        cnt_next      = cnt_reg;
        keep_next     = keep_reg;
        found_next    = found_reg;
        res_kind_next = res_kind_reg;
        res_ent_next  = res_ent_reg;
        own_hb_next   = own_hb_reg;

        ring.op    = RING_HOLD;
        ring.pos   = bnd_reg;
        ring.feed  = head;
        ring.fresh = fresh;

        emit      = 1'b0;
        step      = 1'b0;
        load      = 1'b0;
        load_kind = KIND_GOSSIP;
        load_ent  = head;
        load_cnt  = cnt_reg;
        load_last = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    act_next   = action;
                    eid_next   = entry_id;
                    eport_next = entry_port;
                    ehb_next   = entry_heartbeat;
                    etime_next = entry_time;
                    now_next   = now;
                    rem_next   = cnt_reg;
                    bnd_next   = cnt_reg;
                    found_next = 1'b0;
                    keep_next  = '0;
                    case (action)
                        ACT_MERGE, ACT_GOSSIP:
                        begin
                            state_next = (cnt_reg == '0) ? ST_FINAL : ST_SCAN;
                        end
                        ACT_TICK:
                        begin
                            own_hb_next = own_hb_reg + 1'b1;
                            state_next  = (cnt_reg == '0) ? ST_FINAL : ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SWEEP:
            begin
                // Count the entries that survive the tick
                ring.op = RING_ROT;
                if (age_live)
                begin
                    keep_next = keep_reg + 1'b1;
                end
                rem_next = rem_reg - 1'b1;
                if (rem_reg == CNT_W'(1))
                begin
                    rem_next   = cnt_reg;
                    bnd_next   = cnt_reg;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                case (act_reg)
                    ACT_MERGE:
                    begin
                        step = 1'b1;
                        if (match && !found_reg)
                        begin
                            found_next = 1'b1;
                            if (raise)
                            begin
                                ring.feed     = upd_ent;
                                res_kind_next = KIND_UPDATED;
                                res_ent_next  = upd_ent;
                            end
                            else
                            begin
                                res_kind_next = KIND_UNCHANGED;
                                res_ent_next  = head;
                            end
                        end
                        ring.op = RING_ROT;
                    end
                    ACT_TICK:
                    begin
                        emit      = !age_live;
                        load_kind = KIND_REMOVED;
                        load_cnt  = keep_reg;
                        step      = !emit || out_free;
                        if (step)
                        begin
                            ring.op = emit ? RING_DROP : RING_ROT;
                            if (emit)
                            begin
                                bnd_next = bnd_reg - 1'b1;
                            end
                        end
                    end
                    ACT_GOSSIP:
                    begin
                        emit      = age_fresh;
                        load_kind = KIND_GOSSIP;
                        step      = !emit || out_free;
                        if (step)
                        begin
                            ring.op = RING_ROT;
                        end
                    end
                    default:
                    begin
                        step = 1'b1;
                    end
                endcase
                load = emit && step;
                if (step)
                begin
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == CNT_W'(1))
                    begin
                        state_next = ST_FINAL;
                    end
                end
            end

            ST_FINAL:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    load_last  = 1'b1;
                    state_next = ST_IDLE;
                    case (act_reg)
                        ACT_MERGE:
                        begin
                            if (found_reg)
                            begin
                                load_kind = res_kind_reg;
                                load_ent  = res_ent_reg;
                            end
                            else if (is_self)
                            begin
                                load_kind = KIND_SELF;
                                load_ent  = fresh;
                            end
                            else if (full)
                            begin
                                load_kind = KIND_FULL;
                                load_ent  = fresh;
                            end
                            else
                            begin
                                // Append at the first free cell
                                ring.op   = RING_APPEND;
                                ring.pos  = cnt_reg;
                                cnt_next  = cnt_reg + 1'b1;
                                load_kind = KIND_ADDED;
                                load_ent  = fresh;
                                load_cnt  = cnt_reg + 1'b1;
                            end
                        end
                        ACT_TICK:
                        begin
                            cnt_next  = keep_reg;
                            load_kind = KIND_TICK_DONE;
                            load_ent  = self_ent;
                            load_cnt  = keep_reg;
                        end
                        ACT_GOSSIP:
                        begin
                            load_kind = KIND_GOSSIP;
                            load_ent  = self_ent;
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rem_reg    <= '0;
            bnd_reg    <= '0;
            cnt_reg    <= '0;
            keep_reg   <= '0;
            found_reg  <= 1'b0;
            own_hb_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rem_reg    <= rem_next;
            bnd_reg    <= bnd_next;
            cnt_reg    <= cnt_next;
            keep_reg   <= keep_next;
            found_reg  <= found_next;
            own_hb_reg <= own_hb_next;
        end
    end

    // Hold the captured word and the merge hit
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        eid_reg      <= eid_next;
        eport_reg    <= eport_next;
        ehb_reg      <= ehb_next;
        etime_reg    <= etime_next;
        now_reg      <= now_next;
        res_kind_reg <= res_kind_next;
        res_ent_reg  <= res_ent_next;
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg <= load_kind;
            out_ent_reg  <= load_ent;
            out_cnt_reg  <= load_cnt;
            out_last_reg <= load_last;
        end
    end

    assign result_valid   = out_valid_reg;
    assign kind           = out_kind_reg;
    assign peer_id        = out_ent_reg.id;
    assign peer_port      = out_ent_reg.port;
    assign peer_heartbeat = out_ent_reg.hb;
    assign peer_time      = out_ent_reg.tm;
    assign table_count    = COUNT_W'(out_cnt_reg);
    assign last           = out_last_reg;

endmodule
